### rtl/core/otsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package otsu_pkg;

    localparam int LEVEL_COUNT = 256;
    localparam int COUNT_BITS  = 32;
    localparam int LEVEL_BITS  = $clog2(LEVEL_COUNT);
    // running pixel count and running weighted sum over the bins
    localparam int TN_BITS     = COUNT_BITS + LEVEL_BITS;
    localparam int TS_BITS     = COUNT_BITS + 2 * LEVEL_BITS;
    // narrow multiplier operand holds a product of three class counts
    localparam int MUL_B_BITS  = 3 * TN_BITS;
    // widest cross product: (three terms of s^2 n n) times a three-count product
    localparam int WIDE_BITS   = 2 * TS_BITS + 5 * TN_BITS + 2;
    localparam int RUN_BITS    = TN_BITS + TS_BITS;

    localparam logic [1:0] MODE_ACC  = 2'd0;
    localparam logic [1:0] MODE_COMP = 2'd1;
    localparam logic [1:0] MODE_CLS  = 2'd2;
    localparam logic [1:0] MODE_CLR  = 2'd3;

    localparam logic KIND_LABEL  = 1'b0;
    localparam logic KIND_THRESH = 1'b1;

    localparam logic [1:0] LABEL_LOW  = 2'd0;
    localparam logic [1:0] LABEL_MID  = 2'd1;
    localparam logic [1:0] LABEL_HIGH = 2'd2;

    localparam logic [1:0] NUM_CLASSES_RESET = 2'd2;
    localparam logic [1:0] THREE_CLASSES     = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pixel;
    } t_in;

    typedef struct packed {
        logic       result_kind;
        logic [1:0] class_label;
        logic [7:0] threshold_low;
        logic [7:0] threshold_high;
    } t_out;

    typedef struct packed {
        logic [1:0]            op;
        logic [LEVEL_BITS-1:0] bin;
        logic [7:0]            pixel;
    } t_cmd;

endpackage
`default_nettype wire

### rtl/core/otsu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module otsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/otsu_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module otsu_mul (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [otsu_pkg::WIDE_BITS-1:0]  i_a,
    input  wire logic [otsu_pkg::MUL_B_BITS-1:0] i_b,
    output logic                                  o_done,
    output logic      [otsu_pkg::WIDE_BITS-1:0]  o_p
);
    import otsu_pkg::*;

    logic                  r_busy;
    logic [WIDE_BITS-1:0]  r_a;
    logic [MUL_B_BITS-1:0] r_b;
    logic [WIDE_BITS-1:0]  r_p;

    assign o_done = r_busy && (r_b == '0);
    assign o_p    = r_p;

    // shift and add, one multiplier bit a cycle; stops once the rest is zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_a    <= i_a;
            r_b    <= i_b;
            r_p    <= '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                r_busy <= 1'b0;
            end else begin
                if (r_b[0]) begin
                    r_p <= r_p + r_a;
                end
                r_a <= {r_a[WIDE_BITS-2:0], 1'b0};
                r_b <= {1'b0, r_b[MUL_B_BITS-1:1]};
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/otsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module otsu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire otsu_pkg::t_in   i_item,
    output logic                 o_cmd_valid,
    output otsu_pkg::t_cmd       o_cmd,
    input  wire logic            i_cmd_pop
);
    import otsu_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    assign busy        = (r_cnt == 2'd2);
    assign push        = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // pick the bin here so the back end sees a ready address
    always_comb begin
        cmd_in.op    = i_item.mode;
        cmd_in.pixel = i_item.pixel;
        if (32'(i_item.pixel) >= 32'(LEVEL_COUNT)) begin
            cmd_in.bin = LEVEL_BITS'(LEVEL_COUNT - 1);
        end else begin
            cmd_in.bin = LEVEL_BITS'(i_item.pixel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd_in;
                r_wp      <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/otsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module otsu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [1:0]      i_num_classes,
    input  wire logic            i_cmd_valid,
    input  wire otsu_pkg::t_cmd  i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_res_valid,
    output otsu_pkg::t_out       o_res
);
    import otsu_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ACC_WR = 4'd1;
    localparam logic [3:0] S_PFX    = 4'd2;
    localparam logic [3:0] S_RDR    = 4'd3;
    localparam logic [3:0] S_RDRW   = 4'd4;
    localparam logic [3:0] S_RDC    = 4'd5;
    localparam logic [3:0] S_RDCW   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_MUL_W  = 4'd8;
    localparam logic [3:0] S_NEXT   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [2:0] A_S0   = 3'd0;
    localparam logic [2:0] A_S1   = 3'd1;
    localparam logic [2:0] A_S2   = 3'd2;
    localparam logic [2:0] A_T    = 3'd3;
    localparam logic [2:0] A_N0   = 3'd4;
    localparam logic [2:0] A_DEN  = 3'd5;
    localparam logic [2:0] A_NUM  = 3'd6;
    localparam logic [2:0] A_BNUM = 3'd7;

    localparam logic [2:0] B_S0   = 3'd0;
    localparam logic [2:0] B_S1   = 3'd1;
    localparam logic [2:0] B_S2   = 3'd2;
    localparam logic [2:0] B_N0   = 3'd3;
    localparam logic [2:0] B_N1   = 3'd4;
    localparam logic [2:0] B_N2   = 3'd5;
    localparam logic [2:0] B_BDEN = 3'd6;
    localparam logic [2:0] B_DEN  = 3'd7;

    localparam logic [2:0] D_T       = 3'd0;
    localparam logic [2:0] D_NUM_SET = 3'd1;
    localparam logic [2:0] D_NUM_ADD = 3'd2;
    localparam logic [2:0] D_DEN     = 3'd3;
    localparam logic [2:0] D_L       = 3'd4;
    localparam logic [2:0] D_CMP     = 3'd5;
    localparam logic [2:0] D_BNUM    = 3'd6;

    localparam logic [LEVEL_BITS-1:0] K_TOP  = LEVEL_BITS'(LEVEL_COUNT - 1);
    localparam logic [LEVEL_BITS-1:0] K_LAST = LEVEL_BITS'(LEVEL_COUNT - 2);
    localparam logic [LEVEL_BITS:0]   I_END  = (LEVEL_BITS + 1)'(LEVEL_COUNT);

    typedef struct packed {
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [2:0] dest;
        logic       last;
    } t_uop;

    // score as sum of s_c^2 over n_c, cross-multiplied, then ranked against the best
    function automatic t_uop f_uop(input logic nc3, input logic init, input logic [3:0] step);
        t_uop u;
        u = '{a_sel: A_S0, b_sel: B_S0, dest: D_T, last: 1'b0};
        if (init) begin
            u = '{a_sel: A_S0, b_sel: B_S0, dest: D_BNUM, last: 1'b1};
        end else if (nc3) begin
            case (step)
                4'd0:    u = '{a_sel: A_S0,   b_sel: B_S0,   dest: D_T,       last: 1'b0};
                4'd1:    u = '{a_sel: A_T,    b_sel: B_N1,   dest: D_T,       last: 1'b0};
                4'd2:    u = '{a_sel: A_T,    b_sel: B_N2,   dest: D_NUM_SET, last: 1'b0};
                4'd3:    u = '{a_sel: A_S1,   b_sel: B_S1,   dest: D_T,       last: 1'b0};
                4'd4:    u = '{a_sel: A_T,    b_sel: B_N0,   dest: D_T,       last: 1'b0};
                4'd5:    u = '{a_sel: A_T,    b_sel: B_N2,   dest: D_NUM_ADD, last: 1'b0};
                4'd6:    u = '{a_sel: A_S2,   b_sel: B_S2,   dest: D_T,       last: 1'b0};
                4'd7:    u = '{a_sel: A_T,    b_sel: B_N0,   dest: D_T,       last: 1'b0};
                4'd8:    u = '{a_sel: A_T,    b_sel: B_N1,   dest: D_NUM_ADD, last: 1'b0};
                4'd9:    u = '{a_sel: A_N0,   b_sel: B_N1,   dest: D_DEN,     last: 1'b0};
                4'd10:   u = '{a_sel: A_DEN,  b_sel: B_N2,   dest: D_DEN,     last: 1'b0};
                4'd11:   u = '{a_sel: A_NUM,  b_sel: B_BDEN, dest: D_L,       last: 1'b0};
                default: u = '{a_sel: A_BNUM, b_sel: B_DEN,  dest: D_CMP,     last: 1'b1};
            endcase
        end else begin
            case (step)
                4'd0:    u = '{a_sel: A_S0,   b_sel: B_S0,   dest: D_T,       last: 1'b0};
                4'd1:    u = '{a_sel: A_T,    b_sel: B_N1,   dest: D_NUM_SET, last: 1'b0};
                4'd2:    u = '{a_sel: A_S1,   b_sel: B_S1,   dest: D_T,       last: 1'b0};
                4'd3:    u = '{a_sel: A_T,    b_sel: B_N0,   dest: D_NUM_ADD, last: 1'b0};
                4'd4:    u = '{a_sel: A_N0,   b_sel: B_N1,   dest: D_DEN,     last: 1'b0};
                4'd5:    u = '{a_sel: A_NUM,  b_sel: B_BDEN, dest: D_L,       last: 1'b0};
                default: u = '{a_sel: A_BNUM, b_sel: B_DEN,  dest: D_CMP,     last: 1'b1};
            endcase
        end
        return u;
    endfunction

    function automatic logic [7:0] f_clip8(input logic [LEVEL_BITS-1:0] k);
        logic [31:0] kk;
        kk = 32'(k);
        return (kk > 32'd255) ? 8'd255 : kk[7:0];
    endfunction

    logic [3:0]             r_state;
    logic [LEVEL_COUNT-1:0] r_hvalid;
    logic                   r_hv;
    logic [LEVEL_BITS-1:0]  r_bin;
    logic [LEVEL_BITS:0]    r_i;
    logic                   r_pv;
    logic [LEVEL_BITS-1:0]  r_pi;
    logic [TN_BITS-1:0]     r_tn;
    logic [TS_BITS-1:0]     r_ts;
    logic [LEVEL_BITS-1:0]  r_k1;
    logic [LEVEL_BITS-1:0]  r_k2;
    logic [TN_BITS-1:0]     r_rn1;
    logic [TS_BITS-1:0]     r_rs1;
    logic [TN_BITS-1:0]     r_n0, r_n1, r_n2;
    logic [TS_BITS-1:0]     r_s0, r_s1, r_s2;
    logic [3:0]             r_step;
    logic                   r_init;
    logic                   r_nc3;
    logic [WIDE_BITS-1:0]   r_t, r_num, r_bnum, r_l;
    logic [MUL_B_BITS-1:0]  r_den, r_bden;
    logic [LEVEL_BITS-1:0]  r_best1, r_best2;
    logic [7:0]             r_low, r_high;
    logic                   r_res_valid;
    t_out                   r_res;

    logic [LEVEL_BITS-1:0]  hist_raddr;
    logic [COUNT_BITS-1:0]  hist_rdata;
    logic [COUNT_BITS-1:0]  hist_cnt;
    logic                   hist_we;
    logic [LEVEL_BITS-1:0]  hist_waddr;
    logic [COUNT_BITS-1:0]  hist_wdata;
    logic [LEVEL_BITS-1:0]  run_raddr;
    logic [RUN_BITS-1:0]    run_rdata;
    logic [TN_BITS-1:0]     run_n;
    logic [TS_BITS-1:0]     run_s;
    logic [TN_BITS-1:0]     pfx_tn;
    logic [TS_BITS-1:0]     pfx_ts;
    t_uop                   uop;
    logic                   mul_start;
    logic                   mul_done;
    logic [WIDE_BITS-1:0]   mul_a;
    logic [MUL_B_BITS-1:0]  mul_b;
    logic [WIDE_BITS-1:0]   mul_p;
    logic [TN_BITS-1:0]     c_n0, c_n1, c_n2;
    logic [TS_BITS-1:0]     c_s0, c_s1, c_s2;
    logic                   c_empty;
    logic [7:0]             cut_low, cut_high;
    logic [1:0]             label;

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign hist_raddr = (r_state == S_PFX) ? r_i[LEVEL_BITS-1:0] : i_cmd.bin;
    assign hist_cnt   = r_hv ? hist_rdata : '0;
    assign hist_we    = (r_state == S_ACC_WR);
    assign hist_waddr = r_bin;
    // saturate at the top of the counter
    assign hist_wdata = (hist_cnt == '1) ? hist_cnt : hist_cnt + COUNT_BITS'(1);

    assign pfx_tn = r_tn + TN_BITS'(hist_cnt);
    assign pfx_ts = r_ts + TS_BITS'(r_pi) * TS_BITS'(hist_cnt);

    assign run_raddr = (r_state == S_RDR || !r_nc3) ? r_k1 : r_k2;
    assign run_n     = run_rdata[RUN_BITS-1 -: TN_BITS];
    assign run_s     = run_rdata[TS_BITS-1:0];

    assign uop       = f_uop(r_nc3, r_init, r_step);
    assign mul_start = (r_state == S_MUL);

    otsu_ram #(.WIDTH(COUNT_BITS), .DEPTH(LEVEL_COUNT)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    otsu_ram #(.WIDTH(RUN_BITS), .DEPTH(LEVEL_COUNT)) u_run (
        .i_clk   (i_clk),
        .i_we    (r_pv),
        .i_waddr (r_pi),
        .i_wdata ({pfx_tn, pfx_ts}),
        .i_raddr (run_raddr),
        .o_rdata (run_rdata)
    );

    otsu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_comb begin
        case (uop.a_sel)
            A_S0:    mul_a = WIDE_BITS'(r_s0);
            A_S1:    mul_a = WIDE_BITS'(r_s1);
            A_S2:    mul_a = WIDE_BITS'(r_s2);
            A_T:     mul_a = r_t;
            A_N0:    mul_a = WIDE_BITS'(r_n0);
            A_DEN:   mul_a = WIDE_BITS'(r_den);
            A_NUM:   mul_a = r_num;
            default: mul_a = r_bnum;
        endcase
        case (uop.b_sel)
            B_S0:    mul_b = MUL_B_BITS'(r_s0);
            B_S1:    mul_b = MUL_B_BITS'(r_s1);
            B_S2:    mul_b = MUL_B_BITS'(r_s2);
            B_N0:    mul_b = MUL_B_BITS'(r_n0);
            B_N1:    mul_b = MUL_B_BITS'(r_n1);
            B_N2:    mul_b = MUL_B_BITS'(r_n2);
            B_BDEN:  mul_b = r_bden;
            default: mul_b = r_den;
        endcase
    end

    // class counts and sums of the candidate from the running sums
    always_comb begin
        if (r_nc3) begin
            c_n0 = r_rn1;
            c_s0 = r_rs1;
            c_n1 = run_n - r_rn1;
            c_s1 = run_s - r_rs1;
            c_n2 = r_tn - run_n;
            c_s2 = r_ts - run_s;
        end else begin
            c_n0 = run_n;
            c_s0 = run_s;
            c_n1 = r_tn - run_n;
            c_s1 = r_ts - run_s;
            c_n2 = r_tn;
            c_s2 = r_ts;
        end
        c_empty = (c_n0 == '0) || (c_n1 == '0) || (r_nc3 && (c_n2 == '0));
    end

    always_comb begin
        cut_low  = f_clip8(r_best1);
        cut_high = r_nc3 ? f_clip8(r_best2) : f_clip8(r_best1);
        if (i_cmd.pixel <= r_low) begin
            label = LABEL_LOW;
        end else if (i_num_classes == THREE_CLASSES) begin
            label = (i_cmd.pixel <= r_high) ? LABEL_MID : LABEL_HIGH;
        end else begin
            label = LABEL_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hvalid    <= '0;
            r_pv        <= 1'b0;
            r_low       <= 8'd0;
            r_high      <= 8'd0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            r_hv        <= r_hvalid[hist_raddr];
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.op)
                            MODE_ACC: begin
                                r_bin   <= i_cmd.bin;
                                r_state <= S_ACC_WR;
                            end
                            MODE_COMP: begin
                                r_nc3   <= (i_num_classes == THREE_CLASSES);
                                r_i     <= '0;
                                r_tn    <= '0;
                                r_ts    <= '0;
                                r_state <= S_PFX;
                            end
                            MODE_CLS: begin
                                r_res_valid <= 1'b1;
                                r_res       <= '{result_kind: KIND_LABEL, class_label: label,
                                                 threshold_low: r_low, threshold_high: r_high};
                            end
                            default: begin
                                r_hvalid <= '0;
                            end
                        endcase
                    end
                end
                S_ACC_WR: begin
                    r_hvalid[r_bin] <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_PFX: begin
                    r_pv <= (r_i < I_END);
                    r_pi <= r_i[LEVEL_BITS-1:0];
                    if (r_i < I_END) begin
                        r_i <= r_i + (LEVEL_BITS + 1)'(1);
                    end
                    if (r_pv) begin
                        r_tn <= pfx_tn;
                        r_ts <= pfx_ts;
                    end else if (r_i == I_END) begin
                        // best so far is the zero-variance score S^2 / T
                        r_s0    <= r_ts;
                        r_bden  <= (r_tn == '0) ? MUL_B_BITS'(1) : MUL_B_BITS'(r_tn);
                        r_best1 <= r_nc3 ? LEVEL_BITS'(0) : LEVEL_BITS'(1);
                        r_best2 <= '0;
                        r_k1    <= r_nc3 ? LEVEL_BITS'(0) : LEVEL_BITS'(1);
                        r_init  <= 1'b1;
                        r_step  <= 4'd0;
                        r_state <= S_MUL;
                    end
                end
                S_RDR: begin
                    r_state <= S_RDRW;
                end
                S_RDRW: begin
                    r_rn1   <= run_n;
                    r_rs1   <= run_s;
                    r_k2    <= r_k1 + LEVEL_BITS'(1);
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_state <= S_RDCW;
                end
                S_RDCW: begin
                    r_n0   <= c_n0;
                    r_n1   <= c_n1;
                    r_n2   <= c_n2;
                    r_s0   <= c_s0;
                    r_s1   <= c_s1;
                    r_s2   <= c_s2;
                    r_step <= 4'd0;
                    // an empty class scores zero and never beats the best
                    r_state <= c_empty ? S_NEXT : S_MUL;
                end
                S_MUL: begin
                    r_state <= S_MUL_W;
                end
                S_MUL_W: begin
                    if (mul_done) begin
                        case (uop.dest)
                            D_T:       r_t    <= mul_p;
                            D_NUM_SET: r_num  <= mul_p;
                            D_NUM_ADD: r_num  <= r_num + mul_p;
                            D_DEN:     r_den  <= mul_p[MUL_B_BITS-1:0];
                            D_L:       r_l    <= mul_p;
                            D_BNUM:    r_bnum <= mul_p;
                            default: begin
                                if (r_l > mul_p) begin
                                    r_bnum  <= r_num;
                                    r_bden  <= r_den;
                                    r_best1 <= r_k1;
                                    r_best2 <= r_k2;
                                end
                            end
                        endcase
                        if (!uop.last) begin
                            r_step  <= r_step + 4'd1;
                            r_state <= S_MUL;
                        end else if (r_init) begin
                            r_init  <= 1'b0;
                            r_state <= r_nc3 ? S_RDR : S_RDC;
                        end else begin
                            r_state <= S_NEXT;
                        end
                    end
                end
                S_NEXT: begin
                    if (!r_nc3) begin
                        if (r_k1 == K_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k1    <= r_k1 + LEVEL_BITS'(1);
                            r_state <= S_RDC;
                        end
                    end else if (r_k2 == K_TOP) begin
                        if (r_k1 == K_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k1    <= r_k1 + LEVEL_BITS'(1);
                            r_state <= S_RDR;
                        end
                    end else begin
                        r_k2    <= r_k2 + LEVEL_BITS'(1);
                        r_state <= S_RDC;
                    end
                end
                S_DONE: begin
                    r_low       <= cut_low;
                    r_high      <= cut_high;
                    r_res_valid <= 1'b1;
                    r_res       <= '{result_kind: KIND_THRESH, class_label: LABEL_LOW,
                                     threshold_low: cut_low, threshold_high: cut_high};
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/otsu_multilevel_threshold_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Multilevel Otsu threshold core over a histogram of 8-bit pixels.
// Input: drive i_item with start high; the word is taken at a clock edge where
// busy is low. Modes: accumulate a pixel, compute thresholds, classify a pixel,
// clear the histogram. Words go into a two-entry queue; busy is high when full.
// Output: o_result_valid strobes for one cycle with o_result; the receiver
// cannot stall, so every result must be taken in that cycle.
// Configuration: i_cfg_we writes num_classes (3 = three classes, else two);
// write it only while no word is in flight.
// Path: a taken word is registered in the queue, and the back end pops it while
// idle; a classify result is then registered in the back end before it strobes.
// Back end: clear and classify finish in the idle state; accumulate reads the
// histogram RAM, then writes it in S_ACC_WR, so a stream of accumulates fills the queue and raises busy.
// Compute: prefix sums over all LEVEL_COUNT bins and one multiply for the starting
// score, then per candidate a running-sum read and advance, plus a further read
// per row of pairs with three classes. A candidate with an empty class stops there;
// others add 7 (two classes) or 13 (three classes) bit-serial multiplies, each a
// shift and add over the multiplier bits. Candidates: 254 cuts, or 32640 pairs.
// Reset: histogram empty (valid bits cleared at once), cuts zero, two classes.
module otsu_multilevel_threshold_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire otsu_pkg::t_in   i_item,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_wdata,
    output logic                 o_result_valid,
    output otsu_pkg::t_out       o_result
);
    import otsu_pkg::*;

    logic [1:0] r_num_classes;
    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= NUM_CLASSES_RESET;
        end else if (i_cfg_we) begin
            r_num_classes <= i_cfg_wdata;
        end
    end

    otsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    otsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_num_classes (r_num_classes),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_res_valid   (o_result_valid),
        .o_res         (o_result)
    );
endmodule
`default_nettype wire
